// File: design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define FRT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("frt assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define FRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frt assertion failed");

`else

`define FRT_ASSERT(lbl, clk, rst_n, prop)
`define FRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: design/frt_pkg.sv
`default_nettype none

package frt_pkg;

  localparam int OPEN_ENTRIES  = 8;
  localparam int HISTORY_DEPTH = 8;
  localparam int TIME_WIDTH    = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam int ENT_IDX_W  = (OPEN_ENTRIES > 1) ? $clog2(OPEN_ENTRIES) : 1;
  localparam int HIST_IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int Q_IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OPENED     = 3'd0,
    ST_APPENDED   = 3'd1,
    ST_COMPLETED  = 3'd2,
    ST_DUP_MSG    = 3'd3,
    ST_FIRST_LOST = 3'd4,
    ST_DUP_FRAG   = 3'd5,
    ST_OUT_OF_SEQ = 3'd6,
    ST_TABLE_FULL = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0]  seq_number;
    logic [7:0]  fragment_index;
    logic [7:0]  fragment_count;
    logic [31:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  slot;
    logic [31:0] elapsed_ticks;
  } out_item_t;

  // Fragment header plus the stateless part of its classification.
  typedef struct packed {
    in_item_t   hdr;
    logic       idx_zero;
    logic [7:0] last_idx;
  } frag_cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// File: design/frt_front.sv
`default_nettype none

module frt_front
  import frt_pkg::*;
(
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  input  wire q_status_t q_status,
  output logic           q_push,
  output frag_cls_t      q_data
);

  assign in_ready = !q_status.full;
  assign q_push   = in_valid && in_ready;

  // Precompute the header tests that need no table state.
  always_comb begin
    q_data          = '0;
    q_data.hdr      = in_data;
    q_data.idx_zero = (in_data.fragment_index == 8'd0);
    q_data.last_idx = in_data.fragment_count - 8'd1;
  end

endmodule

`default_nettype wire

// File: design/frt_fifo.sv
`default_nettype none
`include "assert_macros.svh"

module frt_fifo
  import frt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire frag_cls_t push_data,
  input  wire logic      pop,
  output frag_cls_t      pop_data,
  output q_status_t      status
);

  frag_cls_t          mem_r [QUEUE_DEPTH];
  logic [Q_IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [Q_IDX_W-1:0] ptr_inc(input logic [Q_IDX_W-1:0] p);
    logic [Q_IDX_W-1:0] r;
    if (p == Q_IDX_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign status.full  = (cnt_r == Q_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `FRT_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= Q_CNT_W'(QUEUE_DEPTH))
  `FRT_ASSERT(a_no_push_full, clk, rst_n, !(push && status.full))
  `FRT_ASSERT(a_no_pop_empty, clk, rst_n, !(pop && status.empty))

endmodule

`default_nettype wire

// File: design/frt_back.sv
`default_nettype none
`include "assert_macros.svh"

module frt_back
  import frt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire frag_cls_t q_data,
  input  wire q_status_t q_status,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic [OPEN_ENTRIES-1:0]  ent_valid_r, ent_valid_nxt;
  logic [7:0]               ent_seq_r   [OPEN_ENTRIES];
  logic [7:0]               ent_last_r  [OPEN_ENTRIES];
  logic [TIME_WIDTH-1:0]    ent_start_r [OPEN_ENTRIES];
  logic [HISTORY_DEPTH-1:0] hist_valid_r, hist_valid_nxt;
  logic [7:0]               hist_seq_r  [HISTORY_DEPTH];
  logic [HIST_IDX_W-1:0]    hist_ptr_r, hist_ptr_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r;

  logic                  hist_hit;
  logic                  match_found, free_found;
  logic [ENT_IDX_W-1:0]  match_idx, free_idx;
  logic [8:0]            next_idx;
  logic [TIME_WIDTH-1:0] now, diff;
  logic                  open_en, adv_en, close_en, rec_en;
  out_item_t             res;

  assign q_pop     = !q_status.empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign now       = TIME_WIDTH'(q_data.hdr.arrival_time);

  // Parallel compares against the history ring and the open table.
  always_comb begin
    hist_hit = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (hist_valid_r[i] && hist_seq_r[i] == q_data.hdr.seq_number) begin
        hist_hit = 1'b1;
      end
    end
    match_found = 1'b0;
    match_idx   = '0;
    free_found  = 1'b0;
    free_idx    = '0;
    for (int i = OPEN_ENTRIES - 1; i >= 0; i--) begin
      if (ent_valid_r[i] && ent_seq_r[i] == q_data.hdr.seq_number) begin
        match_found = 1'b1;
        match_idx   = ENT_IDX_W'(i);
      end
      if (!ent_valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = ENT_IDX_W'(i);
      end
    end
  end

  assign next_idx = {1'b0, ent_last_r[match_idx]} + 9'd1;
  assign diff     = now - ent_start_r[match_idx];

  // Decide the fate of the fragment at the head of the queue.
  always_comb begin
    open_en  = 1'b0;
    adv_en   = 1'b0;
    close_en = 1'b0;
    rec_en   = 1'b0;
    res      = '0;
    if (hist_hit) begin
      res.status = ST_DUP_MSG;
    end else if (!match_found) begin
      if (!q_data.idx_zero) begin
        res.status = ST_FIRST_LOST;
      end else if (!free_found) begin
        res.status = ST_TABLE_FULL;
      end else if (q_data.last_idx == 8'd0) begin
        rec_en     = 1'b1;
        res.status = ST_COMPLETED;
        res.slot   = 3'(free_idx);
      end else begin
        open_en    = 1'b1;
        res.status = ST_OPENED;
        res.slot   = 3'(free_idx);
      end
    end else if ({1'b0, q_data.hdr.fragment_index} == next_idx) begin
      adv_en   = 1'b1;
      res.slot = 3'(match_idx);
      if (q_data.hdr.fragment_index == q_data.last_idx) begin
        close_en          = 1'b1;
        rec_en            = 1'b1;
        res.status        = ST_COMPLETED;
        res.elapsed_ticks = 32'(diff);
      end else begin
        res.status = ST_APPENDED;
      end
    end else if ({1'b0, q_data.hdr.fragment_index} > next_idx) begin
      res.status = ST_OUT_OF_SEQ;
    end else begin
      res.status = ST_DUP_FRAG;
    end
  end

  always_comb begin
    ent_valid_nxt  = ent_valid_r;
    hist_valid_nxt = hist_valid_r;
    hist_ptr_nxt   = hist_ptr_r;
    if (q_pop && open_en) begin
      ent_valid_nxt[free_idx] = 1'b1;
    end
    if (q_pop && close_en) begin
      ent_valid_nxt[match_idx] = 1'b0;
    end
    if (q_pop && rec_en) begin
      hist_valid_nxt[hist_ptr_r] = 1'b1;
      if (hist_ptr_r == HIST_IDX_W'(HISTORY_DEPTH - 1)) begin
        hist_ptr_nxt = '0;
      end else begin
        hist_ptr_nxt = hist_ptr_r + 1'b1;
      end
    end
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r  <= '0;
      hist_valid_r <= '0;
      hist_ptr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      ent_valid_r  <= ent_valid_nxt;
      hist_valid_r <= hist_valid_nxt;
      hist_ptr_r   <= hist_ptr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && open_en) begin
      ent_seq_r[free_idx]   <= q_data.hdr.seq_number;
      ent_last_r[free_idx]  <= 8'd0;
      ent_start_r[free_idx] <= now;
    end
    if (q_pop && adv_en) begin
      ent_last_r[match_idx] <= q_data.hdr.fragment_index;
    end
    if (q_pop && rec_en) begin
      hist_seq_r[hist_ptr_r] <= q_data.hdr.seq_number;
    end
    if (q_pop) begin
      out_data_r <= res;
    end
  end

  `FRT_ASSERT(a_hist_ptr_range, clk, rst_n,
              hist_ptr_r <= HIST_IDX_W'(HISTORY_DEPTH - 1))
  `FRT_ASSERT_NEXT(a_dup_msg_keeps_table, clk, rst_n, q_pop && hist_hit,
                   $stable(ent_valid_r) && $stable(hist_ptr_r))
  `FRT_ASSERT(a_elapsed_only_completed, clk, rst_n,
              !(out_valid_r && out_data_r.elapsed_ticks != 32'd0 &&
                out_data_r.status != ST_COMPLETED))

endmodule

`default_nettype wire

// File: design/fragment_reassembly_tracker_unit.sv
// Fragment reassembly tracker: decides the fate of each fragment header.
// Input channel (in_valid/in_ready/in_data) carries one header beat: sequence
// number, fragment index, fragment count and a 32-bit arrival tick count.
// Result channel (out_valid/out_ready/out_data) returns exactly one beat per
// header: status code, table slot and elapsed ticks for completed messages.
// The front end classifies headers and pushes them into a two-entry queue;
// the back end checks the completed-message history and the open-message
// table combinationally and updates both; each result is then registered.
// A queued header is popped once the result register is free or being taken.
// Throughput: one header per cycle while out_ready stays high; the back end
// updates its table as it pops each header, which sets that rate.
// Stall: when out_ready is low the result register holds, the back end stops
// popping, and in_ready drops once the queue fills (two more beats).
// Reset (rst_n low, synchronous): empties the queue, clears all open entries,
// the history ring and its write pointer, and drops out_valid.
`default_nettype none

module fragment_reassembly_tracker_unit
  import frt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  // Queue handshake between front and back halves.
  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  frag_cls_t q_wr_data;
  frag_cls_t q_rd_data;

  // Front end: accept header beats, precompute index tests.
  frt_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  // Short queue: decouples input acceptance from result stalls.
  frt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .status    (q_status)
  );

  // Back end: history check, table update, registered result.
  frt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_rd_data),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import frt_pkg::*;

  // Concurrent message lanes in the random traffic, and its length in headers.
  localparam int LANES          = 8;
  localparam int RANDOM_HEADERS = 1464;
  // Sequence number of the message deliberately left stuck at index 255.
  localparam logic [7:0] STUCK_SEQ = 8'd201;

  // Tracks open messages and the delivered-message ring the same way the
  // block does, and holds the verdict each accepted header must produce.
  class fragment_verdict_book;
    bit                        open_valid [OPEN_ENTRIES];
    logic [7:0]                open_seq   [OPEN_ENTRIES];
    logic [7:0]                open_last  [OPEN_ENTRIES];
    logic [TIME_WIDTH-1:0]     open_start [OPEN_ENTRIES];
    bit                        done_valid [HISTORY_DEPTH];
    logic [7:0]                done_seq   [HISTORY_DEPTH];
    int                        done_ptr;
    out_item_t                 pending_verdicts [$];
    int                        mismatches;
    int                        verdicts_checked;
    int                        status_tally [8];

    task flag_mismatch(input string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function void remember_done(input logic [7:0] seq);
      done_valid[done_ptr] = 1'b1;
      done_seq[done_ptr]   = seq;
      done_ptr             = (done_ptr + 1) % HISTORY_DEPTH;
    endfunction

    function out_item_t judge_fragment(input in_item_t f);
      out_item_t  v;
      int         hit;
      int         free_slot;
      int         next_idx;
      logic [7:0] closing_idx;
      v.status        = ST_DUP_MSG;
      v.slot          = '0;
      v.elapsed_ticks = '0;
      hit             = -1;
      free_slot       = -1;
      closing_idx     = f.fragment_count - 8'd1;
      for (int i = 0; i < HISTORY_DEPTH; i++)
        if (done_valid[i] && done_seq[i] == f.seq_number) return v;
      for (int i = 0; i < OPEN_ENTRIES; i++)
        if (hit < 0 && open_valid[i] && open_seq[i] == f.seq_number) hit = i;
      if (hit < 0) begin
        if (f.fragment_index != 8'd0) begin
          v.status = ST_FIRST_LOST;
        end else begin
          for (int i = 0; i < OPEN_ENTRIES; i++)
            if (free_slot < 0 && !open_valid[i]) free_slot = i;
          if (free_slot < 0) begin
            v.status = ST_TABLE_FULL;
          end else begin
            v.slot = 3'(free_slot);
            if (closing_idx == 8'd0) begin
              remember_done(f.seq_number);
              v.status = ST_COMPLETED;
            end else begin
              open_valid[free_slot] = 1'b1;
              open_seq[free_slot]   = f.seq_number;
              open_last[free_slot]  = 8'd0;
              open_start[free_slot] = f.arrival_time;
              v.status              = ST_OPENED;
            end
          end
        end
      end else begin
        next_idx = int'(open_last[hit]) + 1;
        if (int'(f.fragment_index) == next_idx) begin
          open_last[hit] = f.fragment_index;
          v.slot         = 3'(hit);
          if (f.fragment_index == closing_idx) begin
            v.elapsed_ticks = 32'(f.arrival_time - open_start[hit]);
            open_valid[hit] = 1'b0;
            remember_done(f.seq_number);
            v.status = ST_COMPLETED;
          end else begin
            v.status = ST_APPENDED;
          end
        end else if (int'(f.fragment_index) > next_idx) begin
          v.status = ST_OUT_OF_SEQ;
        end else begin
          v.status = ST_DUP_FRAG;
        end
      end
      return v;
    endfunction

    function void note_fragment(input in_item_t f);
      pending_verdicts = {pending_verdicts, judge_fragment(f)};
    endfunction

    task check_verdict(input out_item_t got);
      out_item_t want;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing pending: status %0d slot %0d elapsed %0d",
                                got.status, got.slot, got.elapsed_ticks));
        return;
      end
      want = pending_verdicts.pop_front();
      status_tally[int'(want.status)]++;
      if (got.status !== want.status || got.slot !== want.slot ||
          got.elapsed_ticks !== want.elapsed_ticks)
        flag_mismatch($sformatf("beat %0d: status %0d/%0d slot %0d/%0d elapsed %0d/%0d (got/exp)",
                                verdicts_checked, got.status, want.status, got.slot, want.slot,
                                got.elapsed_ticks, want.elapsed_ticks));
      verdicts_checked++;
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  fragment_verdict_book book;
  int                   headers_sent;
  int                   send_gap_pct;
  int                   drain_gap_pct;
  logic [31:0]          tick;

  fragment_reassembly_tracker_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Result side: sample the handshake as it stood at the edge, then pick the
  // ready level for the next cycle. A zero gap percentage keeps ready high.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_verdict(out_data);
    out_ready <= ($urandom_range(99) >= drain_gap_pct);
  end

  // Advance the arrival tick counter; an occasional big jump makes the
  // elapsed-time subtraction wrap.
  function automatic logic [31:0] advance_ticks();
    if ($urandom_range(49) == 0) tick = tick + $urandom;
    else tick = tick + $urandom_range(3000, 1);
    return tick;
  endfunction

  // Present one header beat and hold it until the block takes it. Valid is
  // only dropped inside an idle gap, so back-to-back beats never see a
  // low-then-high pair of assignments in the same step.
  task automatic push_header(input logic [7:0] seq, input logic [7:0] idx,
                             input logic [7:0] count, input logic [31:0] arrival);
    in_item_t hdr;
    hdr.seq_number     = seq;
    hdr.fragment_index = idx;
    hdr.fragment_count = count;
    hdr.arrival_time   = arrival;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= hdr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_fragment(hdr);
    headers_sent++;
  endtask

  task automatic run_directed();
    // Single-fragment message right after reset: seq 0 must not hit the
    // cleared history ring.
    push_header(8'd0, 8'd0, 8'd1, 32'd0);
    // Same message again: already delivered.
    push_header(8'd0, 8'd0, 8'd1, 32'd5);
    // Unknown message with a nonzero index: its first fragment was lost.
    push_header(8'd1, 8'd255, 8'd255, 32'hFFFF_FFFF);
    // Fill every slot, with start times just below the wrap point.
    for (int k = 0; k < OPEN_ENTRIES; k++)
      push_header(8'(10 + k), 8'd0, 8'd2, 32'hFFFF_FFF0 + 32'(k));
    // No free slot left.
    push_header(8'd18, 8'd0, 8'd2, 32'd100);
    // Repeat of an accepted index, then a skip ahead.
    push_header(8'd10, 8'd0, 8'd2, 32'd101);
    push_header(8'd11, 8'd3, 8'd4, 32'd102);
    // Close all of them after the tick counter has wrapped.
    for (int k = 0; k < OPEN_ENTRIES; k++)
      push_header(8'(10 + k), 8'd1, 8'd2, 32'h10 + 32'(7 * k));
  endtask

  task automatic run_long_messages();
    // Count 0 means the last index is 255: walk every index of the byte.
    for (int k = 0; k < 256; k++)
      push_header(8'd200, 8'(k), 8'd0, advance_ticks());
    // Later beats carry count 1, so their index never matches the closing
    // index; the entry runs up to 255 and can then never advance.
    push_header(STUCK_SEQ, 8'd0, 8'd3, advance_ticks());
    for (int k = 1; k < 256; k++)
      push_header(STUCK_SEQ, 8'(k), 8'd1, advance_ticks());
    push_header(STUCK_SEQ, 8'd255, 8'd1, advance_ticks());
    push_header(STUCK_SEQ, 8'd0, 8'd0, advance_ticks());
  endtask

  // Mostly well-formed interleaved messages with random content, salted with
  // repeats, stale and skipped indexes, late beats of delivered messages and
  // fully random headers.
  task automatic run_random_traffic();
    logic [7:0] lane_seq   [LANES];
    int         lane_count [LANES];
    int         lane_next  [LANES];
    bit         lane_live  [LANES];
    logic [7:0] delivered [$];
    logic [7:0] seq;
    bit         clash;
    int         first;
    int         done_so_far;
    int         lane;
    int         roll;
    first = headers_sent;
    for (int j = 0; j < LANES; j++) lane_live[j] = 1'b0;
    while (headers_sent - first < RANDOM_HEADERS) begin
      done_so_far = headers_sent - first;
      // Swap the idling pattern at one third, drop it at two thirds.
      if (done_so_far * 3 >= 2 * RANDOM_HEADERS) begin
        send_gap_pct  = 0;
        drain_gap_pct = 0;
      end else if (done_so_far * 3 >= RANDOM_HEADERS) begin
        send_gap_pct  = 85;
        drain_gap_pct = 29;
      end
      lane = $urandom_range(LANES - 1);
      roll = $urandom_range(99);
      if (!lane_live[lane]) begin
        if (roll < 60) begin
          // Open a new lane with a sequence number no live lane holds.
          do begin
            seq   = 8'($urandom);
            clash = (seq == STUCK_SEQ);
            for (int j = 0; j < LANES; j++)
              if (lane_live[j] && lane_seq[j] == seq) clash = 1'b1;
          end while (clash);
          lane_seq[lane]   = seq;
          lane_count[lane] = ($urandom_range(99) < 3) ? $urandom_range(40, 9)
                                                      : $urandom_range(6, 1);
          lane_next[lane]  = 0;
          lane_live[lane]  = 1'b1;
        end else if (roll < 75 && delivered.size() > 0) begin
          push_header(delivered[$urandom_range(delivered.size() - 1)],
                      8'($urandom_range(255, 1)), 8'($urandom), advance_ticks());
        end else begin
          push_header(8'($urandom), 8'($urandom), 8'($urandom), $urandom);
        end
      end else if (roll < 85) begin
        push_header(lane_seq[lane], 8'(lane_next[lane]), 8'(lane_count[lane]),
                    advance_ticks());
        lane_next[lane]++;
        if (lane_next[lane] == lane_count[lane]) begin
          lane_live[lane] = 1'b0;
          delivered = {delivered, lane_seq[lane]};
          if (delivered.size() > 12) void'(delivered.pop_front());
        end
      end else if (roll < 92 && lane_next[lane] > 0) begin
        // Repeat the last accepted index or resend an older one.
        push_header(lane_seq[lane], 8'($urandom_range(lane_next[lane] - 1)),
                    8'(lane_count[lane]), advance_ticks());
      end else if (roll < 97) begin
        push_header(lane_seq[lane], 8'(lane_next[lane] + $urandom_range(3, 1)),
                    8'(lane_count[lane]), advance_ticks());
      end else begin
        push_header(8'($urandom), 8'($urandom), 8'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    book          = new;
    headers_sent  = 0;
    send_gap_pct  = 29;
    drain_gap_pct = 85;
    tick          = $urandom;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_long_messages();
    run_random_traffic();
    in_valid <= 1'b0;

    // Drain what is still in flight, then give stray beats a chance to show.
    while (book.pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.pending_verdicts.size() != 0)
      book.flag_mismatch($sformatf("%0d verdicts never arrived", book.pending_verdicts.size()));

    $display("Sent %0d fragment headers, checked %0d result beats, %0d mismatches.",
             headers_sent, book.verdicts_checked, book.mismatches);
    $display("Verdicts: opened %0d appended %0d completed %0d dup-msg %0d first-lost %0d",
             book.status_tally[ST_OPENED], book.status_tally[ST_APPENDED],
             book.status_tally[ST_COMPLETED], book.status_tally[ST_DUP_MSG],
             book.status_tally[ST_FIRST_LOST]);
    $display("          dup-frag %0d out-of-seq %0d table-full %0d",
             book.status_tally[ST_DUP_FRAG], book.status_tally[ST_OUT_OF_SEQ],
             book.status_tally[ST_TABLE_FULL]);
    if (book.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout: run did not finish, %0d verdicts pending",
             book.pending_verdicts.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
